/* rtl/core/tbdp_pkg.sv */
// ----------------------------------------------------------------------------
// tbdp_pkg
// Shared widths, parameter defaults and the stage-to-stage control word for
// the ternary bit-packed dot product.
// ----------------------------------------------------------------------------
package tbdp_pkg;

  // fixed field widths
  localparam int MASK_W = 64;
  localparam int DOT_W  = 10;

  // parameter defaults
  localparam int WORD_BITS_DEF  = 64;
  localparam int MAX_LENGTH_DEF = 256;

  // control that travels with the lane-count result into the accumulator
  typedef struct packed {
    logic valid;
    logic last;
  } tbdp_ctl_t;

endpackage

/* rtl/core/tbdp_lane_count.sv */
// ----------------------------------------------------------------------------
// tbdp_lane_count
// Input register and lane-count stage: registers one word of both vectors,
// then sums +1 for agreeing and -1 for opposing nonzero lanes in a tree.
// ----------------------------------------------------------------------------
module tbdp_lane_count #(
  parameter int WORD_BITS = 64,
  parameter int DELTA_W   = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tbdp_pkg::MASK_W-1:0] in_a_nonzero,
  input  logic [tbdp_pkg::MASK_W-1:0] in_a_negative,
  input  logic [tbdp_pkg::MASK_W-1:0] in_b_nonzero,
  input  logic [tbdp_pkg::MASK_W-1:0] in_b_negative,
  input  logic                       in_last_word,
  output tbdp_pkg::tbdp_ctl_t        word_ctl,
  output logic signed [DELTA_W-1:0]  word_delta,
  input  logic                       word_ready
);
  import tbdp_pkg::*;

  localparam int LVL   = $clog2(WORD_BITS);
  localparam int LEAVES = 1 << LVL;

  // stage 1: input register
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_last_r;
  logic [WORD_BITS-1:0] a_nz_r, a_neg_r, b_nz_r, b_neg_r;
  logic                 s1_load;

  // stage 2: lane count register
  logic                      s2_valid_r, s2_valid_nxt;
  logic                      s2_last_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic                      s2_ready;
  logic                      s2_load;

  // adder tree, heap order: node i sums nodes 2i and 2i+1
  logic signed [DELTA_W-1:0] tree [1:2*LEAVES-1];

  assign s2_ready = !s2_valid_r || word_ready;
  assign s2_load  = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign s1_load  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_load || (s1_valid_r && !s2_ready);
    s2_valid_nxt = s2_load || (s2_valid_r && !word_ready);
  end

  genvar k;
  generate
    for (k = 0; k < LEAVES; k++) begin : g_leaf
      if (k < WORD_BITS) begin : g_lane
        logic both, differ;
        assign both   = a_nz_r[k] & b_nz_r[k];
        assign differ = a_neg_r[k] ^ b_neg_r[k];
        // +1 when signs agree, -1 when they differ, 0 when either is zero
        assign tree[LEAVES+k] = {{(DELTA_W-1){both & differ}}, both};
      end else begin : g_pad
        assign tree[LEAVES+k] = '0;
      end
    end
    for (k = 1; k < LEAVES; k++) begin : g_node
      assign tree[k] = tree[2*k] + tree[2*k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      a_nz_r    <= in_a_nonzero[WORD_BITS-1:0];
      a_neg_r   <= in_a_negative[WORD_BITS-1:0];
      b_nz_r    <= in_b_nonzero[WORD_BITS-1:0];
      b_neg_r   <= in_b_negative[WORD_BITS-1:0];
      s1_last_r <= in_last_word;
    end
    if (s2_load) begin
      delta_r   <= tree[1];
      s2_last_r <= s1_last_r;
    end
  end

  assign word_ctl.valid = s2_valid_r;
  assign word_ctl.last  = s2_last_r;
  assign word_delta     = delta_r;

endmodule

/* rtl/core/tbdp_accum.sv */
// ----------------------------------------------------------------------------
// tbdp_accum
// Running sum with saturation and the result register; the sum clears on the
// last word of a vector pair.
// ----------------------------------------------------------------------------
module tbdp_accum #(
  parameter int MAX_LENGTH = 256,
  parameter int DELTA_W    = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tbdp_pkg::tbdp_ctl_t                 word_ctl,
  input  logic signed [DELTA_W-1:0]           word_delta,
  output logic                                word_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tbdp_pkg::DOT_W-1:0]   out_dot_value
);
  import tbdp_pkg::*;

  localparam int SUM_W = $clog2(MAX_LENGTH + 1) + 1;
  localparam int MX1   = (SUM_W > DELTA_W) ? SUM_W : DELTA_W;
  localparam int EXT_W = ((MX1 > DOT_W) ? MX1 : DOT_W) + 1;
  localparam logic signed [EXT_W-1:0] POS_LIM = EXT_W'(MAX_LENGTH);
  localparam logic signed [EXT_W-1:0] NEG_LIM = EXT_W'(-MAX_LENGTH);

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [EXT_W-1:0] sum_ext, clamped;
  logic                    fire;
  logic                    emit;

  // a last word needs the result slot free or draining this cycle
  assign word_ready = !word_ctl.last || !out_valid_r || out_ready;
  assign fire       = word_ctl.valid && word_ready;
  assign emit       = fire && word_ctl.last;

  always_comb begin
    sum_ext = {{(EXT_W-SUM_W){sum_r[SUM_W-1]}}, sum_r}
            + {{(EXT_W-DELTA_W){word_delta[DELTA_W-1]}}, word_delta};
    if (sum_ext > POS_LIM) begin
      clamped = POS_LIM;
    end else if (sum_ext < NEG_LIM) begin
      clamped = NEG_LIM;
    end else begin
      clamped = sum_ext;
    end

    sum_nxt = sum_r;
    if (fire) begin
      sum_nxt = word_ctl.last ? '0 : clamped[SUM_W-1:0];
    end

    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result carries the low bits of the clamped sum
  always_ff @(posedge clk) begin
    if (emit) begin
      dot_r <= clamped[DOT_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dot_value = dot_r;

endmodule

/* rtl/core/ternary_bitpacked_dot_product.sv */
// ----------------------------------------------------------------------------
// ternary_bitpacked_dot_product
// Dot product of two ternary vectors held as nonzero and negative bit masks,
// one word of both vectors per input word, saturated running sum.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    a/b nonzero and negative masks,
//                                            last_word
//   out      output     out_valid/out_ready  dot_value, one per last word
//
// one word per cycle sustained while no held result stalls a last word; a last
// word passes the input register, the lane-count tree register and the
// accumulator/result register. the lane-count adder tree sets the stage-2 path.
// reset is synchronous, active low, and clears the running sum and all valids.
// a held result stalls only last words reaching the accumulator; ready
// propagates back through the stages combinationally.
// ----------------------------------------------------------------------------
module ternary_bitpacked_dot_product #(
  parameter int WORD_BITS  = tbdp_pkg::WORD_BITS_DEF,
  parameter int MAX_LENGTH = tbdp_pkg::MAX_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tbdp_pkg::MASK_W-1:0]       in_a_nonzero,
  input  logic [tbdp_pkg::MASK_W-1:0]       in_a_negative,
  input  logic [tbdp_pkg::MASK_W-1:0]       in_b_nonzero,
  input  logic [tbdp_pkg::MASK_W-1:0]       in_b_negative,
  input  logic                              in_last_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tbdp_pkg::DOT_W-1:0] out_dot_value
);
  import tbdp_pkg::*;

  localparam int DELTA_W = $clog2(WORD_BITS + 1) + 1;

  tbdp_ctl_t                 word_ctl;
  logic signed [DELTA_W-1:0] word_delta;
  logic                      word_ready;

  tbdp_lane_count #(
    .WORD_BITS (WORD_BITS),
    .DELTA_W   (DELTA_W)
  ) u_lane_count (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_a_nonzero  (in_a_nonzero),
    .in_a_negative (in_a_negative),
    .in_b_nonzero  (in_b_nonzero),
    .in_b_negative (in_b_negative),
    .in_last_word  (in_last_word),
    .word_ctl      (word_ctl),
    .word_delta    (word_delta),
    .word_ready    (word_ready)
  );

  tbdp_accum #(
    .MAX_LENGTH (MAX_LENGTH),
    .DELTA_W    (DELTA_W)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .word_ctl      (word_ctl),
    .word_delta    (word_delta),
    .word_ready    (word_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_dot_value (out_dot_value)
  );

`ifndef SYNTHESIS
  // with no result pending nothing downstream can hold the input side
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low while no result is pending");

  // saturation keeps results inside the bound when it fits the field
  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((MAX_LENGTH > 511) ||
                   ((out_dot_value <= MAX_LENGTH) && (out_dot_value >= -MAX_LENGTH))))
    else $error("result outside saturation range");

  // no result survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
